FILE: design/atp_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed-point constants for the atan2 polynomial pipeline.
// No dependencies; used by every module of the block.

package atp_pkg;

    // Quotient width of the ratio min/max in Q1.15 (holds 1.0 exactly)
    localparam int Q_BITS     = 16;
    // Quotient bits resolved per divider stage and number of divider stages
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = 5;

    // Q.15 constants
    localparam logic [15:0] Q15_ONE  = 16'd32768;
    localparam logic [14:0] Q15_PI_4 = 15'd25736;
    localparam logic [16:0] Q15_PI_2 = 17'd51472;
    localparam logic [16:0] Q15_PI   = 17'd102944;
    localparam logic [13:0] Q15_C0   = 14'd8018;
    localparam logic [11:0] Q15_C1   = 12'd2173;

    // Largest output magnitude, pi in Q2.13
    localparam logic [15:0] Q13_PI   = 16'd25736;

    // Octant, quadrant and sign flags that ride along with each transaction
    typedef struct packed {
        logic yneg;
        logic xneg;
        logic swap;
        logic zero;
    } atp_tag_t;

endpackage

FILE: design/atp_front.sv
`timescale 1ns / 1ps
// Front end: magnitude/sign split, octant swap and first quotient bit.
// Depends on atp_pkg.

module atp_front #(
    parameter int W = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [W-1:0]               in_y,
    input  logic [W-1:0]               in_x,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [W-1:0]               out_rem,
    output logic [W-1:0]               out_mx,
    output logic [atp_pkg::Q_BITS-1:0] out_q,
    output atp_pkg::atp_tag_t          out_tag
);

    logic         v1_reg;
    logic [W-1:0] ay_reg;
    logic [W-1:0] ax_reg;
    logic         yneg_reg;
    logic         xneg_reg;

    logic                       v2_reg;
    logic [W-1:0]               rem_reg;
    logic [W-1:0]               mx_reg;
    logic [atp_pkg::Q_BITS-1:0] q_reg;
    atp_pkg::atp_tag_t          tag_reg;

    logic         rdy1;
    logic         rdy2;
    logic [W-1:0] ay_next;
    logic [W-1:0] ax_next;
    logic         swap;
    logic         eq;
    logic [W-1:0] mn;
    logic [W-1:0] mx;
    logic [W-1:0]               rem_next;
    logic [atp_pkg::Q_BITS-1:0] q_next;
    atp_pkg::atp_tag_t          tag_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Most negative value maps to 2^(W-1), still representable unsigned
    assign ay_next = in_y[W-1] ? (~in_y + {{(W-1){1'b0}}, 1'b1}) : in_y;
    assign ax_next = in_x[W-1] ? (~in_x + {{(W-1){1'b0}}, 1'b1}) : in_x;

    always_comb begin
        swap = ay_reg > ax_reg;
        eq   = ay_reg == ax_reg;
        mn   = swap ? ax_reg : ay_reg;
        mx   = swap ? ay_reg : ax_reg;
        // Top quotient bit is set only on the diagonal, where min == max
        q_next        = {{(atp_pkg::Q_BITS-1){1'b0}}, eq};
        rem_next      = eq ? '0 : mn;
        tag_next.yneg = yneg_reg;
        tag_next.xneg = xneg_reg;
        tag_next.swap = swap;
        tag_next.zero = eq && (ay_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            ay_reg   <= ay_next;
            ax_reg   <= ax_next;
            yneg_reg <= in_y[W-1];
            xneg_reg <= in_x[W-1];
        end
        if (rdy2 && v1_reg) begin
            rem_reg <= rem_next;
            mx_reg  <= mx;
            q_reg   <= q_next;
            tag_reg <= tag_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_rem   = rem_reg;
    assign out_mx    = mx_reg;
    assign out_q     = q_reg;
    assign out_tag   = tag_reg;

endmodule

FILE: design/atp_div_stage.sv
`timescale 1ns / 1ps
// One stage of the restoring divider: resolves a few quotient bits of min/max.
// Depends on atp_pkg.

module atp_div_stage #(
    parameter int W = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [W-1:0]               in_rem,
    input  logic [W-1:0]               in_mx,
    input  logic [atp_pkg::Q_BITS-1:0] in_q,
    input  atp_pkg::atp_tag_t          in_tag,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [W-1:0]               out_rem,
    output logic [W-1:0]               out_mx,
    output logic [atp_pkg::Q_BITS-1:0] out_q,
    output atp_pkg::atp_tag_t          out_tag
);

    logic                       v_reg;
    logic [W-1:0]               rem_reg;
    logic [W-1:0]               mx_reg;
    logic [atp_pkg::Q_BITS-1:0] q_reg;
    atp_pkg::atp_tag_t          tag_reg;

    logic                       rdy;
    logic [W-1:0]               rem_next;
    logic [W-1:0]               sh;
    logic [atp_pkg::Q_BITS-1:0] q_next;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    // Remainder stays below max <= 2^(W-1), so the doubled value fits in W bits
    always_comb begin
        rem_next = in_rem;
        q_next   = in_q;
        sh       = '0;
        for (int i = 0; i < atp_pkg::DIV_STEPS; i++) begin
            sh = {rem_next[W-2:0], 1'b0};
            if (sh >= in_mx) begin
                rem_next = sh - in_mx;
                q_next   = {q_next[atp_pkg::Q_BITS-2:0], 1'b1};
            end else begin
                rem_next = sh;
                q_next   = {q_next[atp_pkg::Q_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy && in_valid) begin
            rem_reg <= rem_next;
            mx_reg  <= in_mx;
            q_reg   <= q_next;
            tag_reg <= in_tag;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_mx    = mx_reg;
    assign out_q     = q_reg;
    assign out_tag   = tag_reg;

endmodule

FILE: design/atp_poly.sv
`timescale 1ns / 1ps
// Polynomial arctangent of the Q1.15 ratio plus octant/quadrant/sign repair.
// Four register stages; depends on atp_pkg.

module atp_poly (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       in_r,
    input  atp_pkg::atp_tag_t in_tag,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       out_angle
);

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    logic [27:0]       cp_reg;
    logic [31:0]       tp_reg;
    logic [30:0]       lp_reg;
    logic [27:0]       pp_reg;
    logic [14:0]       l_reg;
    logic [16:0]       m_reg;
    logic [15:0]       angle_reg;
    atp_pkg::atp_tag_t tag1_reg;
    atp_pkg::atp_tag_t tag2_reg;
    atp_pkg::atp_tag_t tag3_reg;

    logic        rdy1;
    logic        rdy2;
    logic        rdy3;
    logic        rdy4;
    logic [27:0] cp_next;
    logic [31:0] tp_next;
    logic [30:0] lp_next;
    logic [13:0] c;
    logic [13:0] t;
    logic [27:0] pp_next;
    logic [16:0] m_sum;
    logic [16:0] m_next;
    logic [16:0] m_quad;
    logic [16:0] m_rnd;
    logic [15:0] q13;
    logic [15:0] angle_next;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1: the three products on r
    assign cp_next = {16'd0, atp_pkg::Q15_C1} * {12'd0, in_r};
    assign tp_next = {16'd0, in_r} * {16'd0, atp_pkg::Q15_ONE - in_r};
    assign lp_next = {16'd0, atp_pkg::Q15_PI_4} * {15'd0, in_r};

    // Stage 2: r*(1-r) times the linear correction
    assign c       = atp_pkg::Q15_C0 + {1'b0, cp_reg[27:15]};
    assign t       = tp_reg[28:15];
    assign pp_next = {14'd0, t} * {14'd0, c};

    // Stage 3: first-octant angle, then fold back across the diagonal
    assign m_sum  = {2'b00, l_reg} + {4'd0, pp_reg[27:15]};
    assign m_next = tag2_reg.swap ? (atp_pkg::Q15_PI_2 - m_sum) : m_sum;

    // Stage 4: mirror into the left half-plane, round to Q2.13, apply sign
    always_comb begin
        m_quad = tag3_reg.xneg ? (atp_pkg::Q15_PI - m_reg) : m_reg;
        m_rnd  = m_quad + 17'd2;
        q13    = {1'b0, m_rnd[16:2]};
        if (tag3_reg.zero) begin
            angle_next = '0;
        end else if (tag3_reg.yneg) begin
            angle_next = 16'd0 - q13;
        end else begin
            angle_next = q13;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            cp_reg   <= cp_next;
            tp_reg   <= tp_next;
            lp_reg   <= lp_next;
            tag1_reg <= in_tag;
        end
        if (rdy2 && v1_reg) begin
            pp_reg   <= pp_next;
            l_reg    <= lp_reg[29:15];
            tag2_reg <= tag1_reg;
        end
        if (rdy3 && v2_reg) begin
            m_reg    <= m_next;
            tag3_reg <= tag2_reg;
        end
        if (rdy4 && v3_reg) begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_angle = angle_reg;

endmodule

FILE: design/atan2_poly_approx.sv
`timescale 1ns / 1ps
// Top level of the four-quadrant atan2 pipeline.
// Depends on atp_pkg, atp_front, atp_div_stage and atp_poly.

// One (y, x) pair is accepted every clock unless the output stalls, and one
// Q2.13 angle leaves per pair, in order. The path runs through two front-end
// stages (magnitude and octant swap), five divider stages of three quotient
// bits each for the low 15 bits of the ratio min/max, and four stages for the
// polynomial multipliers and the angle repair. Every stage has its own valid
// bit and the ready chain lets bubbles close up, so a stalled output does not
// stop intake until the pipeline is full. The origin returns 0.

module atan2_poly_approx #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields from bit 0 up: coord_y, coord_x, zero padding
    input  logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0 up: angle
    output logic [15:0]           m_tdata
);

    localparam int W       = COORD_WIDTH;
    localparam int NS      = atp_pkg::DIV_STAGES;

    logic                       valid_c [NS+1];
    logic                       ready_c [NS+1];
    logic [W-1:0]               rem_c   [NS+1];
    logic [W-1:0]               mx_c    [NS+1];
    logic [atp_pkg::Q_BITS-1:0] q_c     [NS+1];
    atp_pkg::atp_tag_t          tag_c   [NS+1];

    atp_front #(
        .W(W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_y     (s_tdata[W-1:0]),
        .in_x     (s_tdata[2*W-1:W]),
        .out_valid(valid_c[0]),
        .out_ready(ready_c[0]),
        .out_rem  (rem_c[0]),
        .out_mx   (mx_c[0]),
        .out_q    (q_c[0]),
        .out_tag  (tag_c[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_div
        atp_div_stage #(
            .W(W)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (valid_c[g]),
            .in_ready (ready_c[g]),
            .in_rem   (rem_c[g]),
            .in_mx    (mx_c[g]),
            .in_q     (q_c[g]),
            .in_tag   (tag_c[g]),
            .out_valid(valid_c[g+1]),
            .out_ready(ready_c[g+1]),
            .out_rem  (rem_c[g+1]),
            .out_mx   (mx_c[g+1]),
            .out_q    (q_c[g+1]),
            .out_tag  (tag_c[g+1])
        );
    end

    atp_poly u_poly (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (valid_c[NS]),
        .in_ready (ready_c[NS]),
        .in_r     (q_c[NS]),
        .in_tag   (tag_c[NS]),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_angle(m_tdata)
    );

    // Empty output stage means every stage upstream can take data
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output stage is empty");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= $signed(atp_pkg::Q13_PI)) &&
                     ($signed(m_tdata) >= -$signed(atp_pkg::Q13_PI)))
        else $error("angle outside of -pi..pi");

    a_empty_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_no_last_remainder_blowup: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_c[NS] && !tag_c[NS].zero |-> (q_c[NS] <= atp_pkg::Q15_ONE))
        else $error("ratio above one out of divider");

endmodule
